// ----- design/censored_fir_convolver_defines.svh -----
// Assertion macros for the censored FIR convolver.
// Each macro takes a label, clock, reset, antecedent and consequent.
`ifndef CENSORED_FIR_CONVOLVER_DEFINES_SVH
`define CENSORED_FIR_CONVOLVER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle.
`define CFC_ASSERT_NOW(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("cfc assertion failed");

// Consequent must hold in the following cycle.
`define CFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("cfc assertion failed");

`else

`define CFC_ASSERT_NOW(label, clk, rst, ante, cons)
`define CFC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- design/cfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cfc_pkg;

   localparam int MAX_TAPS   = 256;
   localparam int INDEX_BITS = 16;

   localparam int TAP_AW = $clog2(MAX_TAPS);
   localparam int TAP_CW = $clog2(MAX_TAPS + 1);

   localparam int ACTION_W   = 2;
   localparam int TAP_IDX_W  = 8;
   localparam int TAP_W      = 24;
   localparam int SAMPLE_W   = 32;
   localparam int PROD_W     = TAP_W + SAMPLE_W;
   localparam int ACC_W      = 64;

   localparam int KLEN_W     = 9;
   localparam int THRESH_W   = 31;
   localparam int LIMIT_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [KLEN_W-1:0]   KLEN_RESET   = 9'd141;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd8533248;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd0;

   // 99999.0 in Q40.24
   localparam logic [ACC_W-1:0] CENSOR_MARK = 64'h0000_0186_9F00_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_LENGTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENSOR_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_LIMIT     = 2'd2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD    = 2'd0,
      ACT_SAMPLE  = 2'd1,
      ACT_DRAIN   = 2'd2,
      ACT_RESTART = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // Memory and datapath control from the sequencer
   typedef struct packed {
      logic [TAP_AW-1:0]          kern_raddr;
      logic [TAP_AW-1:0]          hist_raddr;
      logic                       hist_we;
      logic [TAP_AW-1:0]          hist_waddr;
      logic signed [SAMPLE_W-1:0] hist_wdata;
      logic                       mac_clear;
      logic                       rd_valid;
      logic                       rd_hist_valid;
   } seq_mem_type;

   // Result hand-off from the sequencer
   typedef struct packed {
      logic                  load;
      logic [INDEX_BITS-1:0] index;
      logic                  censored;
   } seq_res_type;

endpackage

`default_nettype wire

// ----- design/cfc_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cfc_req_if import cfc_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [ACTION_W-1:0]         action;
   logic [TAP_IDX_W-1:0]        tap_index;
   logic signed [TAP_W-1:0]     tap_value;
   logic signed [SAMPLE_W-1:0]  sample_value;

   modport source (output valid, action, tap_index, tap_value, sample_value,
                   input ready);
   modport sink   (input valid, action, tap_index, tap_value, sample_value,
                   output ready);
endinterface

`default_nettype wire

// ----- design/cfc_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cfc_rsp_if import cfc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [ACC_W-1:0]  out_value;
   logic [INDEX_BITS-1:0]    out_index;
   logic                     censored;
   logic                     saturated;

   modport source (output valid, out_value, out_index, censored, saturated,
                   input ready);
   modport sink   (input valid, out_value, out_index, censored, saturated,
                   output ready);
endinterface

`default_nettype wire

// ----- design/cfc_csr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cfc_csr_if import cfc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/cfc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- design/cfc_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfc_mac import cfc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       in_valid,
   input  logic signed [TAP_W-1:0]    tap,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic signed [ACC_W-1:0]    acc,
   output logic                       sat,
   output logic                       busy
);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_v_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     sat_ff, sat_in;
   logic [ACC_W:0]           sum;

   // Register the product before the add
   always_ff @(posedge clock) begin
      prod_ff <= tap * sample;
      if (reset) begin
         prod_v_ff <= 1'b0;
      end else begin
         prod_v_ff <= in_valid;
      end
   end

   always_comb begin
      sum    = {acc_ff[ACC_W-1], acc_ff}
             + {{(ACC_W + 1 - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      acc_in = acc_ff;
      sat_in = sat_ff;
      if (clear) begin
         acc_in = '0;
         sat_in = 1'b0;
      end else if (prod_v_ff) begin
         if (sum[ACC_W] != sum[ACC_W-1]) begin
            // clip and keep accumulating from the limit
            acc_in = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            sat_in = 1'b1;
         end else begin
            acc_in = sum[ACC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sat_ff <= sat_in;
   end

   assign acc  = acc_ff;
   assign sat  = sat_ff;
   assign busy = prod_v_ff;

endmodule

`default_nettype wire

// ----- design/cfc_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfc_seq import cfc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_fire,
   input  action_type                 req_action,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [KLEN_W-1:0]          kernel_length,
   input  logic [THRESH_W-1:0]        censor_threshold,
   input  logic [LIMIT_W-1:0]         output_limit,
   input  logic                       mac_busy,
   input  logic                       out_free,
   output logic                       req_ready,
   output seq_mem_type                mem,
   output seq_res_type                res
);

   state_type               state_ff, state_in;
   logic [TAP_CW-1:0]       tap_cnt_ff, tap_cnt_in;
   logic [TAP_AW-1:0]       hist_addr_ff, hist_addr_in;
   logic [TAP_AW-1:0]       ptr_ff, ptr_in;
   logic [INDEX_BITS-1:0]   cnt_ff, cnt_in;
   logic                    cens_ff, cens_in;
   logic [MAX_TAPS-1:0]     hvld_ff, hvld_in;
   logic                    rd_v_ff, rd_hv_ff;

   logic [TAP_CW-1:0]       len;
   logic [SAMPLE_W-1:0]     mag;
   logic                    cens_now;
   logic                    step;
   logic                    issue;
   logic                    suppress;
   logic                    retire;
   logic signed [SAMPLE_W-1:0] x;

   always_comb begin
      len = (32'(kernel_length) > MAX_TAPS) ? TAP_CW'(MAX_TAPS) : TAP_CW'(kernel_length);
      mag = req_sample[SAMPLE_W-1] ? (~req_sample + SAMPLE_W'(1)) : req_sample;
      cens_now = (req_action == ACT_SAMPLE) && (mag >= SAMPLE_W'(censor_threshold));
      x = ((req_action == ACT_SAMPLE) && !cens_now) ? req_sample : '0;
      step = req_fire && (req_action inside {ACT_SAMPLE, ACT_DRAIN});
      issue = (state_ff == ST_RUN);
      suppress = (output_limit != '0) && (32'(cnt_ff) >= 32'(output_limit));
      retire = (state_ff == ST_DONE) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      tap_cnt_in   = tap_cnt_ff;
      hist_addr_in = hist_addr_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      cens_in      = cens_ff;
      hvld_in      = hvld_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_action == ACT_RESTART)) begin
               hvld_in = '0;
               ptr_in  = '0;
               cnt_in  = '0;
            end else if (step) begin
               hvld_in[ptr_ff] = 1'b1;
               cens_in      = cens_now;
               tap_cnt_in   = '0;
               hist_addr_in = ptr_ff;
               state_in     = (len == '0) ? ST_FLUSH : ST_RUN;
            end
         end
         ST_RUN: begin
            // walk taps forward and history backward
            tap_cnt_in   = tap_cnt_ff + TAP_CW'(1);
            hist_addr_in = (hist_addr_ff == '0) ? TAP_AW'(MAX_TAPS - 1)
                                                 : hist_addr_ff - TAP_AW'(1);
            if ((tap_cnt_ff + TAP_CW'(1)) == len) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!rd_v_ff && !mac_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               ptr_in   = (ptr_ff == TAP_AW'(MAX_TAPS - 1)) ? '0 : ptr_ff + TAP_AW'(1);
               cnt_in   = cnt_ff + INDEX_BITS'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tap_cnt_ff   <= tap_cnt_in;
      hist_addr_ff <= hist_addr_in;
      cens_ff      <= cens_in;
      rd_hv_ff     <= hvld_ff[hist_addr_ff];
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff   <= '0;
         cnt_ff   <= '0;
         hvld_ff  <= '0;
         rd_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         cnt_ff   <= cnt_in;
         hvld_ff  <= hvld_in;
         rd_v_ff  <= issue;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      mem.kern_raddr    = tap_cnt_ff[TAP_AW-1:0];
      mem.hist_raddr    = hist_addr_ff;
      mem.hist_we       = step;
      mem.hist_waddr    = ptr_ff;
      mem.hist_wdata    = x;
      mem.mac_clear     = step;
      mem.rd_valid      = rd_v_ff;
      mem.rd_hist_valid = rd_hv_ff;
      res.load          = retire && !suppress;
      res.index         = cnt_ff;
      res.censored      = cens_ff;
   end

endmodule

`default_nettype wire

// ----- design/censored_fir_convolver.sv -----
// Channel   Dir  Beat carries                                    Accepted when
// req_if    in   action, tap_index, tap_value, sample_value      valid && ready
// rsp_if    out  out_value, out_index, censored, saturated       valid && ready
// csr_if    in   index, data (kernel length, threshold, limit)   valid && ready
//
// A sample or drain beat walks its L taps in use, or none if L is zero:
// one tap a cycle through the single shared multiply-accumulate, fed by one
// read port on each of the tap and history memories, then a drain of the
// read and product stages. Load and restart beats complete on acceptance.
// Reset is synchronous and active high; it empties the history at once
// through per-entry valid bits, so no clearing pass runs. A stalled result
// waits in the output register while the next beat is taken and worked.
`timescale 1ns / 1ps
`default_nettype none
`include "censored_fir_convolver_defines.svh"

module censored_fir_convolver import cfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   cfc_req_if.sink     req_if,
   cfc_rsp_if.source   rsp_if,
   cfc_csr_if.sink     csr_if
);

   // Configuration registers
   logic [KLEN_W-1:0]   klen_ff;
   logic [THRESH_W-1:0] thresh_ff;
   logic [LIMIT_W-1:0]  limit_ff;

   // Output register
   logic                    rsp_vld_ff;
   logic signed [ACC_W-1:0] rsp_value_ff;
   logic [INDEX_BITS-1:0]   rsp_index_ff;
   logic                    rsp_cens_ff;
   logic                    rsp_sat_ff;

   logic                       req_ready;
   logic                       req_fire;
   action_type                 req_action;
   logic                       kern_we;
   logic                       out_free;
   seq_mem_type                mem;
   seq_res_type                res;
   logic [TAP_W-1:0]           kern_q;
   logic [SAMPLE_W-1:0]        hist_q;
   logic signed [SAMPLE_W-1:0] mac_sample;
   logic signed [ACC_W-1:0]    mac_acc;
   logic                       mac_sat;
   logic                       mac_busy;

   assign req_action = action_type'(req_if.action);
   assign req_fire   = req_if.valid && req_ready;
   assign req_if.ready = req_ready;

   // Drop tap loads that fall outside the kernel store
   assign kern_we = req_fire && (req_action == ACT_LOAD)
                 && (32'(req_if.tap_index) < MAX_TAPS);

   // Take register writes in every cycle; the block is idle by contract
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff   <= KLEN_RESET;
         thresh_ff <= THRESH_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_KERNEL_LENGTH:    klen_ff   <= csr_if.data[KLEN_W-1:0];
            CSR_CENSOR_THRESHOLD: thresh_ff <= csr_if.data[THRESH_W-1:0];
            CSR_OUTPUT_LIMIT:     limit_ff  <= csr_if.data[LIMIT_W-1:0];
            default: begin
               // unmapped index: ignore the beat
            end
         endcase
      end
   end

   cfc_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_fire         (req_fire),
      .req_action       (req_action),
      .req_sample       (req_if.sample_value),
      .kernel_length    (klen_ff),
      .censor_threshold (thresh_ff),
      .output_limit     (limit_ff),
      .mac_busy         (mac_busy),
      .out_free         (out_free),
      .req_ready        (req_ready),
      .mem              (mem),
      .res              (res)
   );

   // Kernel taps: written by load beats, walked by the sequencer
   cfc_ram #(
      .WIDTH (TAP_W),
      .DEPTH (MAX_TAPS)
   ) u_kern_ram (
      .clock (clock),
      .we    (kern_we),
      .waddr (TAP_AW'(req_if.tap_index)),
      .wdata (req_if.tap_value),
      .raddr (mem.kern_raddr),
      .rdata (kern_q)
   );

   // Sample history ring: the new sample is written on acceptance, so the
   // first read, in the cycle after, already sees it
   cfc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_TAPS)
   ) u_hist_ram (
      .clock (clock),
      .we    (mem.hist_we),
      .waddr (mem.hist_waddr),
      .wdata (mem.hist_wdata),
      .raddr (mem.hist_raddr),
      .rdata (hist_q)
   );

   // Entries not written since the last restart or reset read as zero
   assign mac_sample = mem.rd_hist_valid ? $signed(hist_q) : '0;

   cfc_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .clear    (mem.mac_clear),
      .in_valid (mem.rd_valid),
      .tap      ($signed(kern_q)),
      .sample   (mac_sample),
      .acc      (mac_acc),
      .sat      (mac_sat),
      .busy     (mac_busy)
   );

   // Hold the result until taken; the sequencer only retires into a free slot
   assign out_free = !rsp_vld_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (res.load) begin
         rsp_value_ff <= res.censored ? $signed(CENSOR_MARK) : mac_acc;
         rsp_index_ff <= res.index;
         rsp_cens_ff  <= res.censored;
         rsp_sat_ff   <= res.censored ? 1'b0 : mac_sat;
      end
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (res.load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   assign rsp_if.valid     = rsp_vld_ff;
   assign rsp_if.out_value = rsp_value_ff;
   assign rsp_if.out_index = rsp_index_ff;
   assign rsp_if.censored  = rsp_cens_ff;
   assign rsp_if.saturated = rsp_sat_ff;

   // A new beat only enters with the read and product stages empty
   `CFC_ASSERT_NOW(a_pipe_empty_on_accept, clock, reset, req_fire, !mem.rd_valid && !mac_busy)
   // A result is only retired into a free output slot and then shows
   `CFC_ASSERT_NEXT(a_result_shows, clock, reset, res.load && out_free, rsp_vld_ff)
   // A retire never coincides with taking a new beat
   `CFC_ASSERT_NOW(a_no_retire_on_accept, clock, reset, res.load, !req_fire)
   // A censored result carries the marker and never a saturation flag
   `CFC_ASSERT_NOW(a_censor_marker, clock, reset, rsp_vld_ff && rsp_cens_ff, !rsp_sat_ff && (rsp_value_ff == $signed(CENSOR_MARK)))

endmodule

`default_nettype wire

// ----- tb/sv/fir_result_checker.sv -----
`timescale 1ns / 1ps

module fir_result_checker import cfc_pkg::*; (
   input  logic clock,
   input  logic reset,
   cfc_req_if   req_mon,
   cfc_rsp_if   rsp_mon,
   cfc_csr_if   csr_mon,
   output int   mismatch_count,
   output int   pending_results
);

   typedef struct packed {
      logic [ACC_W-1:0]      value;
      logic [INDEX_BITS-1:0] index;
      logic                  censored;
      logic                  saturated;
   } fir_result_type;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   fir_result_type          expected_outputs [$];
   logic signed [TAP_W-1:0]    tap_mirror  [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] history_mirror [MAX_TAPS];
   logic [TAP_AW-1:0]          write_slot;
   logic [INDEX_BITS-1:0]      series_index;
   logic [KLEN_W-1:0]          taps_in_use;
   logic [THRESH_W-1:0]        threshold;
   logic [LIMIT_W-1:0]         index_limit;

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
   end

   task automatic clear_series();
      for (int n = 0; n < MAX_TAPS; n++) history_mirror[n] = '0;
      write_slot   = '0;
      series_index = '0;
   endtask

   // Work out the output beat (if any) caused by one accepted request beat
   task automatic convolve_beat(input action_type act, input logic [TAP_IDX_W-1:0] ti,
                                input logic signed [TAP_W-1:0] tv,
                                input logic signed [SAMPLE_W-1:0] sv);
      logic signed [SAMPLE_W-1:0] x;
      logic signed [ACC_W-1:0]    acc;
      logic signed [ACC_W-1:0]    prod;
      logic [ACC_W:0]             wide;
      logic                       cens;
      logic                       sat;
      longint                     mag;
      int                         count;
      logic [TAP_AW-1:0]          slot;
      logic [INDEX_BITS-1:0]      idx;
      fir_result_type             res;
      case (act)
         ACT_LOAD: tap_mirror[ti] = tv;
         ACT_RESTART: clear_series();
         default: begin
            x    = '0;
            cens = 1'b0;
            sat  = 1'b0;
            acc  = '0;
            if (act == ACT_SAMPLE) begin
               mag = (sv < 0) ? -longint'(sv) : longint'(sv);
               if (mag >= longint'(threshold)) cens = 1'b1;
               else x = sv;
            end
            history_mirror[write_slot] = x;
            count = (int'(taps_in_use) > MAX_TAPS) ? MAX_TAPS : int'(taps_in_use);
            for (int n = 0; n < count; n++) begin
               slot = write_slot - TAP_AW'(n);
               prod = ACC_W'(longint'(tap_mirror[n]) * longint'(history_mirror[slot]));
               wide = {acc[ACC_W-1], acc} + {prod[ACC_W-1], prod};
               // clip and carry on from the clipped value
               if (wide[ACC_W] != wide[ACC_W-1]) begin
                  sat = 1'b1;
                  acc = wide[ACC_W] ? ACC_MIN : ACC_MAX;
               end else begin
                  acc = wide[ACC_W-1:0];
               end
            end
            write_slot   = write_slot + 1'b1;
            idx          = series_index;
            series_index = series_index + 1'b1;
            if (index_limit == '0 || idx < index_limit) begin
               res.value     = cens ? CENSOR_MARK : acc;
               res.index     = idx;
               res.censored  = cens;
               res.saturated = cens ? 1'b0 : sat;
               expected_outputs.push_back(res);
            end
         end
      endcase
   endtask

   task automatic compare_output();
      fir_result_type want;
      if (expected_outputs.size() == 0) begin
         if (mismatch_count < 10)
            $display("unpredicted output beat: value %h index %0d censored %0b saturated %0b",
                     rsp_mon.out_value, rsp_mon.out_index, rsp_mon.censored,
                     rsp_mon.saturated);
         mismatch_count++;
      end else begin
         want = expected_outputs.pop_front();
         if (want.value !== rsp_mon.out_value || want.index !== rsp_mon.out_index ||
             want.censored !== rsp_mon.censored || want.saturated !== rsp_mon.saturated) begin
            if (mismatch_count < 10)
               $display("mismatch (exp/got): value %h/%h index %0d/%0d cens %0b/%0b sat %0b/%0b",
                        want.value, rsp_mon.out_value, want.index, rsp_mon.out_index,
                        want.censored, rsp_mon.censored, want.saturated, rsp_mon.saturated);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < MAX_TAPS; n++) tap_mirror[n] = '0;
         clear_series();
         taps_in_use = KLEN_RESET;
         threshold   = THRESH_RESET;
         index_limit = LIMIT_RESET;
         expected_outputs.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_KERNEL_LENGTH:    taps_in_use = csr_mon.data[KLEN_W-1:0];
               CSR_CENSOR_THRESHOLD: threshold   = csr_mon.data[THRESH_W-1:0];
               CSR_OUTPUT_LIMIT:     index_limit = csr_mon.data[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) compare_output();
         if (req_mon.valid && req_mon.ready)
            convolve_beat(action_type'(req_mon.action), req_mon.tap_index,
                          req_mon.tap_value, req_mon.sample_value);
      end
      pending_results = expected_outputs.size();
   end

endmodule

// ----- tb/sv/tb_censored_fir_convolver.sv -----
`timescale 1ns / 1ps

module tb_censored_fir_convolver;
   import cfc_pkg::*;

   // longest kernel walk is 256 taps plus the pipeline drain: settle well past it
   localparam int SETTLE_CYCLES = 300;
   localparam int HOLD_CYCLES   = 1500;
   localparam int CYCLE_LIMIT   = 3_000_000;
   // the register map leaves this index unused; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   mismatch_count;
   int   pending_results;

   bit   tap_loaded [MAX_TAPS];
   bit   sender_idles;
   bit   receiver_idles;
   bit   hold_request;
   logic [THRESH_W-1:0] cur_thresh;

   cfc_req_if req_bus ();
   cfc_rsp_if rsp_bus ();
   cfc_csr_if csr_bus ();

   censored_fir_convolver uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   fir_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_mon         (csr_bus),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("censored_fir_convolver test failed");
         $finish;
      end
   end

   // Result side: draw a stall per beat, then hold ready until a beat is taken.
   // A hold request from the stimulus swaps the short stall for a long one, so
   // the output register fills, the next beat is worked and the input backs up.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = receiver_idles ? $urandom_range(0, 6) : 0;
         if (hold_request) begin
            stall        = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Offer one request beat after any random gap; keep valid high across
   // back-to-back beats so it never drops and rises in the same step.
   task automatic send_beat(input action_type act, input logic [TAP_IDX_W-1:0] ti,
                            input logic [TAP_W-1:0] tv, input logic [SAMPLE_W-1:0] sv);
      int gap;
      gap = sender_idles ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= act;
      req_bus.tap_index    <= ti;
      req_bus.tap_value    <= tv;
      req_bus.sample_value <= sv;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Unused fields of each beat carry junk so every bit toggles
   task automatic send_sample(input logic [SAMPLE_W-1:0] sv);
      send_beat(ACT_SAMPLE, TAP_IDX_W'($urandom), TAP_W'($urandom), sv);
   endtask

   task automatic send_drain();
      send_beat(ACT_DRAIN, TAP_IDX_W'($urandom), TAP_W'($urandom), SAMPLE_W'($urandom));
   endtask

   task automatic send_restart();
      send_beat(ACT_RESTART, TAP_IDX_W'($urandom), TAP_W'($urandom), SAMPLE_W'($urandom));
   endtask

   task automatic send_load(input logic [TAP_IDX_W-1:0] ti, input logic [TAP_W-1:0] tv);
      tap_loaded[ti] = 1'b1;
      send_beat(ACT_LOAD, ti, tv, SAMPLE_W'($urandom));
   endtask

   function automatic logic [TAP_W-1:0] pick_tap();
      logic [TAP_W-1:0] v;
      case ($urandom_range(0, 5))
         0: v = 24'h7F_FFFF;
         1: v = 24'h80_0000;
         2, 3: v = TAP_W'($urandom);
         default: begin
            v = TAP_W'($urandom_range(0, 32'h3_FFFF));
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   // Samples cluster below, at and beyond the current threshold
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] v;
      case ($urandom_range(0, 7))
         0: v = $urandom;
         1: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: begin
            v = {1'b0, cur_thresh} + SAMPLE_W'($urandom_range(0, 2)) - 32'd1;
            if ($urandom_range(0, 1)) v = -v;
         end
         3, 4, 5: begin
            v = $urandom % ({1'b0, cur_thresh} + 32'd1);
            if ($urandom_range(0, 1)) v = -v;
         end
         6: v = '0;
         default: begin
            v = SAMPLE_W'($urandom_range(0, 1023));
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   // Write all three registers plus the spare index in one burst of beats;
   // junk above each field checks that only the field bits are taken.
   task automatic write_settings(input logic [KLEN_W-1:0] klen,
                                 input logic [THRESH_W-1:0] thresh,
                                 input logic [LIMIT_W-1:0] limit);
      logic [CSR_IDX_W-1:0]  regs [4];
      logic [CSR_DATA_W-1:0] vals [4];
      regs[0] = CSR_KERNEL_LENGTH;
      regs[1] = CSR_CENSOR_THRESHOLD;
      regs[2] = CSR_OUTPUT_LIMIT;
      regs[3] = CSR_SPARE;
      vals[0] = $urandom;
      vals[0][KLEN_W-1:0] = klen;
      vals[1] = $urandom;
      vals[1][THRESH_W-1:0] = thresh;
      vals[2] = $urandom;
      vals[2][LIMIT_W-1:0] = limit;
      vals[3] = $urandom;
      for (int n = 0; n < 4; n++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= regs[n];
         csr_bus.data  <= vals[n];
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
      cur_thresh = thresh;
   endtask

   // Drop valid, let every predicted beat arrive, then settle past the
   // longest kernel walk in case a suppressed output is still being worked.
   task automatic wait_until_idle();
      req_bus.valid <= 1'b0;
      do begin
         while (pending_results != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end while (pending_results != 0);
   endtask

   // Every tap the kernel walk will read has to be loaded first
   task automatic load_taps_in_use(input logic [KLEN_W-1:0] klen);
      int count;
      count = (int'(klen) > MAX_TAPS) ? MAX_TAPS : int'(klen);
      for (int n = 0; n < count; n++)
         if (!tap_loaded[n]) send_load(TAP_IDX_W'(n), pick_tap());
   endtask

   task automatic random_beats(input int items, input int restart_pct);
      int r;
      for (int n = 0; n < items; n++) begin
         r = $urandom_range(0, 99);
         if (r < restart_pct) send_restart();
         else if (r < restart_pct + 12) send_load(TAP_IDX_W'($urandom), pick_tap());
         else if (r < restart_pct + 32) send_drain();
         else send_sample(pick_sample());
      end
   endtask

   task automatic run_phase(input logic [KLEN_W-1:0] klen, input logic [THRESH_W-1:0] thresh,
                            input logic [LIMIT_W-1:0] limit, input int items,
                            input int restart_pct);
      wait_until_idle();
      write_settings(klen, thresh, limit);
      load_taps_in_use(klen);
      random_beats(items, restart_pct);
   endtask

   initial begin
      logic [KLEN_W-1:0]   klen;
      logic [THRESH_W-1:0] thresh;
      logic [LIMIT_W-1:0]  limit;

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.action       <= ACT_LOAD;
      req_bus.tap_index    <= '0;
      req_bus.tap_value    <= '0;
      req_bus.sample_value <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= '0;
      csr_bus.data         <= '0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      hold_request   = 1'b0;
      cur_thresh     = THRESH_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: four taps at the extremes and at plus and minus 0x010000, the
      // top tap slot, then samples at the range limits and either side of
      // the reset threshold in both signs, four tail drains and a restart.
      write_settings(9'd4, THRESH_RESET, 16'd0);
      send_load(8'd0, 24'h7F_FFFF);
      send_load(8'd1, 24'h80_0000);
      send_load(8'd2, 24'h01_0000);
      send_load(8'd3, 24'hFF_0000);
      send_load(8'd255, 24'h12_3456);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h0000_0000);
      send_sample(32'h0000_0001);
      send_sample(32'hFFFF_FFFF);
      send_sample({1'b0, THRESH_RESET} - 32'd1);
      send_sample({1'b0, THRESH_RESET});
      send_sample(-{1'b0, THRESH_RESET});
      send_sample(32'd1 - {1'b0, THRESH_RESET});
      repeat (4) send_drain();
      send_restart();
      send_sample(32'h0000_0180);
      send_drain();

      // No taps in use, top threshold, outputs from index three suppressed
      wait_until_idle();
      write_settings(9'd0, 31'h7FFF_FFFF, 16'd3);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h7FFF_FFFE);
      send_drain();
      send_drain();
      send_restart();
      send_sample(32'h0000_0005);

      // Zero threshold censors every sample, zero included; drains stay clean
      wait_until_idle();
      write_settings(9'd2, 31'd0, 16'd0);
      send_sample(32'h0000_0000);
      send_drain();

      // Random phases over a spread of settings, idling switched per phase
      for (int p = 0; p < 12; p++) begin
         case ($urandom_range(0, 9))
            0: klen = 9'd0;
            1: klen = KLEN_W'($urandom_range(17, 64));
            default: klen = KLEN_W'($urandom_range(1, 16));
         endcase
         case ($urandom_range(0, 4))
            0: thresh = '0;
            1: thresh = 31'h7FFF_FFFF;
            2: thresh = THRESH_RESET;
            3: thresh = THRESH_W'($urandom);
            default: thresh = THRESH_W'($urandom_range(256, 32'h10_0000));
         endcase
         case ($urandom_range(0, 9))
            7: limit = LIMIT_W'($urandom_range(1, 60));
            8: limit = 16'hFFFF;
            9: limit = LIMIT_W'($urandom_range(1, 200));
            default: limit = '0;
         endcase
         sender_idles   = (p % 4) != 3;
         receiver_idles = (p % 3) != 2;
         run_phase(klen, thresh, limit, 60, $urandom_range(0, 8));
      end

      // Back-pressure: no sender gaps while the receiver holds off for a long stretch
      wait_until_idle();
      sender_idles   = 1'b0;
      receiver_idles = 1'b1;
      write_settings(9'd6, THRESH_RESET, 16'd0);
      load_taps_in_use(9'd6);
      hold_request = 1'b1;
      random_beats(150, 0);

      // History wrap: no restarts, enough steps to lap the history store
      sender_idles = 1'b1;
      run_phase(9'd16, THRESH_RESET, 16'd0, 320, 0);

      // Full kernel, then a length beyond the store that clamps to it
      run_phase(9'd256, 31'h7FFF_FFFF, 16'd0, 40, 3);
      run_phase(9'd511, THRESH_RESET, 16'd0, 30, 3);

      wait_until_idle();
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("censored_fir_convolver test passed");
      end else begin
         $display("censored_fir_convolver test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/cfc_pkg.sv
design/cfc_req_if.sv
design/cfc_rsp_if.sv
design/cfc_csr_if.sv
design/cfc_ram.sv
design/cfc_mac.sv
design/cfc_seq.sv
design/censored_fir_convolver.sv
tb/sv/fir_result_checker.sv
tb/sv/tb_censored_fir_convolver.sv
